/* rtl/cfa_pkg.sv */
package cfa_pkg;

   localparam int LIMBS       = 5;
   localparam int COLS        = 2 * LIMBS - 1;
   localparam int LIMB_W      = 55;
   localparam int OUT_W       = 56;
   localparam int RADIX       = 51;
   localparam int HALF_LO     = 28;
   localparam int HALF_HI     = LIMB_W - HALF_LO;
   localparam int PP_W        = 2 * HALF_LO;
   localparam int PROD_W      = 2 * LIMB_W;
   localparam int COL_W       = 120;
   localparam int CARRY_STEPS = 7;
   // lane stages + column sum + fold + carry steps
   localparam int PIPE_DEPTH  = 2 + 2 + CARRY_STEPS;

   localparam logic [COL_W-1:0] MASK51     = COL_W'(51'h7FFFFFFFFFFFF);
   localparam logic [OUT_W-1:0] TWO_P_LOW  = OUT_W'(52'hFFFFFFFFFFFDA);
   localparam logic [OUT_W-1:0] TWO_P_HIGH = OUT_W'(52'hFFFFFFFFFFFFE);
   localparam logic [LIMB_W-1:0] A24       = LIMB_W'(121666);

   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_SUB    = 3'd1,
      KIND_MUL    = 3'd2,
      KIND_SQUARE = 3'd3,
      KIND_MUL24  = 3'd4,
      KIND_CSWAP  = 3'd5
   } kind_type;

   typedef logic [LIMB_W-1:0]          limb_type;
   typedef limb_type [LIMBS-1:0]       elem_type;
   typedef logic [OUT_W-1:0]           res_type;
   typedef res_type [LIMBS-1:0]        rese_type;
   typedef logic [PROD_W-1:0]          prod_type;
   typedef prod_type [LIMBS-1:0]       row_type;
   typedef row_type [LIMBS-1:0]        grid_type;
   typedef logic [COL_W-1:0]           col_type;
   typedef col_type [LIMBS-1:0]        acc_type;

   typedef struct packed {
      logic     use_mul;
      logic     is_swap;
      rese_type a;
      rese_type b;
   } side_type;

   // 19*x as shifts and adds
   function automatic col_type fold19(col_type x);
      return (x << 4) + (x << 1) + x;
   endfunction

   // f + 2p - g, g first carried once around (fold by 19)
   function automatic rese_type field_sub(elem_type f, elem_type g);
      rese_type t;
      rese_type h;
      logic [OUT_W-1:0] top;
      for (int i = 0; i < LIMBS; i++) t[i] = OUT_W'(g[i]);
      for (int i = 0; i < LIMBS - 1; i++) begin
         t[i+1] = t[i+1] + (t[i] >> RADIX);
         t[i]   = t[i] & OUT_W'(MASK51);
      end
      top  = t[LIMBS-1] >> RADIX;
      t[0] = t[0] + (top << 4) + (top << 1) + top;
      t[LIMBS-1] = t[LIMBS-1] & OUT_W'(MASK51);
      t[1] = t[1] + (t[0] >> RADIX);
      t[0] = t[0] & OUT_W'(MASK51);
      h[0] = OUT_W'(f[0]) + TWO_P_LOW - t[0];
      for (int i = 1; i < LIMBS; i++) h[i] = OUT_W'(f[i]) + TWO_P_HIGH - t[i];
      return h;
   endfunction

endpackage

/* rtl/cfa_lane.sv */
module cfa_lane import cfa_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  limb_type f_limb,
   input  elem_type g_elem,
   output row_type  prod_row
);

   logic [LIMBS-1:0][PP_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [LIMBS-1:0][PP_W-1:0] ll_in, lh_in, hl_in, hh_in;
   row_type prod_ff, prod_in;
   logic [HALF_LO-1:0] f_lo;
   logic [HALF_HI-1:0] f_hi;

   assign f_lo = f_limb[HALF_LO-1:0];
   assign f_hi = f_limb[LIMB_W-1:HALF_LO];

   // split 55x55 into four products of at most 28x28
   always_comb begin
      for (int j = 0; j < LIMBS; j++) begin
         ll_in[j] = PP_W'(f_lo) * PP_W'(g_elem[j][HALF_LO-1:0]);
         lh_in[j] = PP_W'(f_lo) * PP_W'(g_elem[j][LIMB_W-1:HALF_LO]);
         hl_in[j] = PP_W'(f_hi) * PP_W'(g_elem[j][HALF_LO-1:0]);
         hh_in[j] = PP_W'(f_hi) * PP_W'(g_elem[j][LIMB_W-1:HALF_LO]);
      end
   end

   always_comb begin
      for (int j = 0; j < LIMBS; j++) begin
         prod_in[j] = PROD_W'(ll_ff[j])
                    + ((PROD_W'(lh_ff[j]) + PROD_W'(hl_ff[j])) << HALF_LO)
                    + (PROD_W'(hh_ff[j]) << (2 * HALF_LO));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         prod_ff <= prod_in;
      end
   end

   assign prod_row = prod_ff;

endmodule

/* rtl/cfa_merge.sv */
module cfa_merge import cfa_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  grid_type prods,
   output acc_type  h
);

   col_type [COLS-1:0] col_ff, col_in;
   acc_type fold_ff, fold_in;
   acc_type step_ff [CARRY_STEPS];

   always_comb begin
      col_in = '0;
      for (int i = 0; i < LIMBS; i++) begin
         for (int j = 0; j < LIMBS; j++) begin
            col_in[i+j] = col_in[i+j] + COL_W'(prods[i][j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LIMBS - 1; i++) fold_in[i] = col_ff[i] + fold19(col_ff[i+LIMBS]);
      fold_in[LIMBS-1] = col_ff[LIMBS-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff  <= col_in;
         fold_ff <= fold_in;
      end
   end

   // carry chain: 0->1, 1->2, 2->3, 3->4, 4->0 (x19), 0->1, 1->2
   for (genvar s = 0; s < CARRY_STEPS; s++) begin : g_step
      localparam int SRC = (s < LIMBS) ? s : s - LIMBS;
      localparam int DST = (SRC == LIMBS - 1) ? 0 : SRC + 1;
      acc_type prev, step_in;
      col_type carry;

      if (s == 0) begin : g_first
         assign prev = fold_ff;
      end else begin : g_next
         assign prev = step_ff[s-1];
      end

      always_comb begin
         step_in      = prev;
         carry        = prev[SRC] >> RADIX;
         step_in[SRC] = prev[SRC] & MASK51;
         if (SRC == LIMBS - 1) step_in[DST] = prev[DST] + fold19(carry);
         else                  step_in[DST] = prev[DST] + carry;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            step_ff[s] <= step_in;
         end
      end
   end

   assign h = step_ff[CARRY_STEPS-1];

endmodule

/* rtl/curve25519_field_alu_unit.sv */
// Field arithmetic unit for GF(2^255-19), five limbs of radix 2^51 per element.
// Input channel (req_*): kind, operands f and g, swap control. One item in,
// exactly one item out (rsp_*), in order.
// Multiply, square and multiply-by-121666 share five multiplier lanes, one
// per limb of f; each lane forms a row of 5 limb products from 28x28 partial
// products. A merge stage sums the columns, folds the high columns by 19 and
// runs the partial carry chain, one carry per stage.
// Add, sub and cswap are done at entry and ride alongside in a side pipe.
// Throughput: one item per cycle unless the receiver stalls; the whole
// pipeline advances together.
// The pipeline advances when the output register is empty or being taken,
// so req_ready follows rsp_ready: a stalled receiver freezes all stages and
// holds the result in place until taken.
// Reset (synchronous, active high) clears all valid flags; data registers
// are not reset.
module curve25519_field_alu_unit import cfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  limb_type    req_f_limb0,
   input  limb_type    req_f_limb1,
   input  limb_type    req_f_limb2,
   input  limb_type    req_f_limb3,
   input  limb_type    req_f_limb4,
   input  limb_type    req_g_limb0,
   input  limb_type    req_g_limb1,
   input  limb_type    req_g_limb2,
   input  limb_type    req_g_limb3,
   input  limb_type    req_g_limb4,
   input  logic        req_swap,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output res_type     rsp_out_a0,
   output res_type     rsp_out_a1,
   output res_type     rsp_out_a2,
   output res_type     rsp_out_a3,
   output res_type     rsp_out_a4,
   output res_type     rsp_out_b0,
   output res_type     rsp_out_b1,
   output res_type     rsp_out_b2,
   output res_type     rsp_out_b3,
   output res_type     rsp_out_b4
);

   logic      en;
   elem_type  f, g, g_eff;
   side_type  side_in;
   side_type  side_ff [PIPE_DEPTH];
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic      rsp_valid_ff;
   rese_type  out_a_ff, out_b_ff, out_a_in;
   logic      out_mul_ff, out_swap_ff;
   grid_type  prods;
   acc_type   h;

   // whole pipe moves when the output slot is free or being taken
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   assign f = {req_f_limb4, req_f_limb3, req_f_limb2, req_f_limb1, req_f_limb0};
   assign g = {req_g_limb4, req_g_limb3, req_g_limb2, req_g_limb1, req_g_limb0};

   // operand decode: square uses f twice, mul121666 uses g = {121666,0,0,0,0}
   always_comb begin
      side_in = '0;
      g_eff   = '0;
      case (req_kind)
         KIND_ADD: begin
            for (int i = 0; i < LIMBS; i++) side_in.a[i] = OUT_W'(f[i]) + OUT_W'(g[i]);
         end
         KIND_SUB: begin
            side_in.a = field_sub(f, g);
         end
         KIND_MUL: begin
            g_eff           = g;
            side_in.use_mul = 1'b1;
         end
         KIND_SQUARE: begin
            g_eff           = f;
            side_in.use_mul = 1'b1;
         end
         KIND_MUL24: begin
            g_eff[0]        = A24;
            side_in.use_mul = 1'b1;
         end
         KIND_CSWAP: begin
            side_in.is_swap = 1'b1;
            for (int i = 0; i < LIMBS; i++) begin
               side_in.a[i] = OUT_W'(req_swap ? g[i] : f[i]);
               side_in.b[i] = OUT_W'(req_swap ? f[i] : g[i]);
            end
         end
         default: begin
            side_in = '0;
         end
      endcase
   end

   for (genvar i = 0; i < LIMBS; i++) begin : g_lane
      cfa_lane u_lane (
         .clock    (clock),
         .en       (en),
         .f_limb   (f[i]),
         .g_elem   (g_eff),
         .prod_row (prods[i])
      );
   end

   cfa_merge u_merge (
      .clock (clock),
      .en    (en),
      .prods (prods),
      .h     (h)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= valid_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < PIPE_DEPTH; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   always_comb begin
      for (int i = 0; i < LIMBS; i++) begin
         out_a_in[i] = side_ff[PIPE_DEPTH-1].use_mul ? h[i][OUT_W-1:0]
                                                     : side_ff[PIPE_DEPTH-1].a[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_a_ff    <= out_a_in;
         out_b_ff    <= side_ff[PIPE_DEPTH-1].b;
         out_mul_ff  <= side_ff[PIPE_DEPTH-1].use_mul;
         out_swap_ff <= side_ff[PIPE_DEPTH-1].is_swap;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_a0 = out_a_ff[0];
   assign rsp_out_a1 = out_a_ff[1];
   assign rsp_out_a2 = out_a_ff[2];
   assign rsp_out_a3 = out_a_ff[3];
   assign rsp_out_a4 = out_a_ff[4];
   assign rsp_out_b0 = out_b_ff[0];
   assign rsp_out_b1 = out_b_ff[1];
   assign rsp_out_b2 = out_b_ff[2];
   assign rsp_out_b3 = out_b_ff[3];
   assign rsp_out_b4 = out_b_ff[4];

   // second element is zero for every kind but cswap
   a_b_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_swap_ff |-> out_b_ff == '0)
      else $error("second element nonzero outside cswap");

   // carried limbs of a product are reduced to 51 bits
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_mul_ff |->
         out_a_ff[0][OUT_W-1:RADIX] == '0 && out_a_ff[1][OUT_W-1:RADIX] == '0 &&
         out_a_ff[3][OUT_W-1:RADIX] == '0 && out_a_ff[4][OUT_W-1:RADIX] == '0)
      else $error("product limb not reduced");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && valid_ff == '0)
      else $error("pipeline not empty after reset");

endmodule

/* sim/tb_curve25519_field_alu_unit.sv */
`timescale 1ns / 100ps

module tb_curve25519_field_alu_unit;
   import cfa_pkg::*;

   // kinds the block does not define; they must return an all-zero result
   localparam logic [2:0] KIND_UNDEF6 = 3'd6;
   localparam logic [2:0] KIND_UNDEF7 = 3'd7;

   localparam logic [LIMB_W-1:0] LIMB_MAX = {LIMB_W{1'b1}};
   localparam logic [LIMB_W-1:0] L51_MAX  = 55'h7FFFFFFFFFFFF;
   localparam logic [63:0]       M51      = 64'h7FFFFFFFFFFFF;
   localparam int                N_ITEMS  = 1200;

   typedef struct {
      res_type a[LIMBS];
      res_type b[LIMBS];
   } field_result_type;

   // one directed row; operands are uniform across limbs unless rnd is set
   typedef struct {
      logic [2:0]  kind;
      limb_type    fv;
      limb_type    gv;
      logic        sw;
      logic        rnd;
      logic        typed;
      res_type     ea0;
      res_type     ea_hi;
      res_type     eb;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_kind  = '0;
   limb_type   f_drv [LIMBS];
   limb_type   g_drv [LIMBS];
   logic       req_swap  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   res_type    rsp_a [LIMBS];
   res_type    rsp_b [LIMBS];

   // typed-in expectation for the item on the bus (directed rows only)
   logic             typed_on = 1'b0;
   field_result_type typed_res;

   field_result_type expected_q[$];
   int errors      = 0;
   int accepted    = 0;
   int checked     = 0;
   int kind_seen[8];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < LIMBS; i++) begin
         f_drv[i] = '0;
         g_drv[i] = '0;
      end
   end

   curve25519_field_alu_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_f_limb0 (f_drv[0]),
      .req_f_limb1 (f_drv[1]),
      .req_f_limb2 (f_drv[2]),
      .req_f_limb3 (f_drv[3]),
      .req_f_limb4 (f_drv[4]),
      .req_g_limb0 (g_drv[0]),
      .req_g_limb1 (g_drv[1]),
      .req_g_limb2 (g_drv[2]),
      .req_g_limb3 (g_drv[3]),
      .req_g_limb4 (g_drv[4]),
      .req_swap    (req_swap),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_a0  (rsp_a[0]),
      .rsp_out_a1  (rsp_a[1]),
      .rsp_out_a2  (rsp_a[2]),
      .rsp_out_a3  (rsp_a[3]),
      .rsp_out_a4  (rsp_a[4]),
      .rsp_out_b0  (rsp_b[0]),
      .rsp_out_b1  (rsp_b[1]),
      .rsp_out_b2  (rsp_b[2]),
      .rsp_out_b3  (rsp_b[3]),
      .rsp_out_b4  (rsp_b[4])
   );

   // ---------------------------------------------------------------
   // Field arithmetic predictor. Wide sums are kept mod 2^128 and limb
   // sums of sub / mul121666 mod 2^64, same as the block's definition.
   // ---------------------------------------------------------------
   function automatic void field_mul_pred(input limb_type x[LIMBS],
                                          input limb_type y[LIMBS],
                                          output res_type h[LIMBS]);
      logic [127:0] col[9];
      for (int i = 0; i < 9; i++) col[i] = '0;
      for (int i = 0; i < LIMBS; i++)
         for (int j = 0; j < LIMBS; j++)
            col[i+j] = col[i+j] + 128'(x[i]) * 128'(y[j]);
      // fold high columns by 19
      for (int i = 0; i < 4; i++) col[i] = col[i] + col[i+5] * 128'd19;
      for (int i = 0; i < 4; i++) begin
         col[i+1] = col[i+1] + (col[i] >> RADIX);
         col[i]   = col[i] & 128'(M51);
      end
      col[0] = col[0] + (col[4] >> RADIX) * 128'd19;
      col[4] = col[4] & 128'(M51);
      col[1] = col[1] + (col[0] >> RADIX);
      col[0] = col[0] & 128'(M51);
      col[2] = col[2] + (col[1] >> RADIX);
      col[1] = col[1] & 128'(M51);
      for (int i = 0; i < LIMBS; i++) h[i] = col[i][OUT_W-1:0];
   endfunction

   function automatic field_result_type predict_field_op(input logic [2:0] kind,
                                                         input limb_type x[LIMBS],
                                                         input limb_type y[LIMBS],
                                                         input logic sw);
      field_result_type r;
      logic [63:0]  t[LIMBS];
      logic [63:0]  h[LIMBS];
      logic [127:0] c[LIMBS];
      logic [63:0]  k;
      for (int i = 0; i < LIMBS; i++) begin
         r.a[i] = '0;
         r.b[i] = '0;
      end
      case (kind)
         KIND_ADD: begin
            for (int i = 0; i < LIMBS; i++) r.a[i] = OUT_W'(x[i]) + OUT_W'(y[i]);
         end
         KIND_SUB: begin
            // carry g once around, then f + 2p - g
            for (int i = 0; i < LIMBS; i++) t[i] = 64'(y[i]);
            for (int i = 0; i < 4; i++) begin
               t[i+1] = t[i+1] + (t[i] >> RADIX);
               t[i]   = t[i] & M51;
            end
            t[0] = t[0] + (t[4] >> RADIX) * 64'd19;
            t[4] = t[4] & M51;
            t[1] = t[1] + (t[0] >> RADIX);
            t[0] = t[0] & M51;
            h[0] = 64'(x[0]) + 64'(TWO_P_LOW) - t[0];
            for (int i = 1; i < LIMBS; i++) h[i] = 64'(x[i]) + 64'(TWO_P_HIGH) - t[i];
            for (int i = 0; i < LIMBS; i++) r.a[i] = h[i][OUT_W-1:0];
         end
         KIND_MUL:    field_mul_pred(x, y, r.a);
         KIND_SQUARE: field_mul_pred(x, x, r.a);
         KIND_MUL24: begin
            for (int i = 0; i < LIMBS; i++) c[i] = 128'(x[i]) * 128'd121666;
            for (int i = 0; i < 4; i++) begin
               c[i+1] = c[i+1] + (c[i] >> RADIX);
               h[i]   = c[i][63:0] & M51;
            end
            k    = 64'(c[4] >> RADIX);
            h[4] = c[4][63:0] & M51;
            h[0] = h[0] + k * 64'd19;
            k    = h[0] >> RADIX;
            h[0] = h[0] & M51;
            h[1] = h[1] + k;
            k    = h[1] >> RADIX;
            h[1] = h[1] & M51;
            h[2] = h[2] + k;
            for (int i = 0; i < LIMBS; i++) r.a[i] = h[i][OUT_W-1:0];
         end
         KIND_CSWAP: begin
            for (int i = 0; i < LIMBS; i++) begin
               r.a[i] = OUT_W'(sw ? y[i] : x[i]);
               r.b[i] = OUT_W'(sw ? x[i] : y[i]);
            end
         end
         default: ;  // undefined kinds: all zero
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Monitor: record accepted items, check accepted results in order.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      field_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (typed_on) expected_q.push_back(typed_res);
            else expected_q.push_back(predict_field_op(req_kind, f_drv, g_drv, req_swap));
            accepted++;
            kind_seen[req_kind]++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               want = expected_q.pop_front();
               checked++;
               for (int i = 0; i < LIMBS; i++) begin
                  if (rsp_a[i] !== want.a[i]) begin
                     $error("out_a%0d: expected %h, got %h", i, want.a[i], rsp_a[i]);
                     errors++;
                  end
                  if (rsp_b[i] !== want.b[i]) begin
                     $error("out_b%0d: expected %h, got %h", i, want.b[i], rsp_b[i]);
                     errors++;
                  end
               end
            end
         end
      end
   end

   // receiver backpressure, redrawn every cycle
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // random limb: full width, top of range, 51-bit, or small
   function automatic limb_type rand_limb();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7))
         0:       return LIMB_MAX;
         1:       return limb_type'(v) & L51_MAX;
         2:       return limb_type'($urandom_range(3));
         3:       return LIMB_MAX - limb_type'($urandom_range(3));
         default: return limb_type'(v);
      endcase
   endfunction

   // Drive one item: idle cycles drawn per cycle, then hold valid until
   // accepted. Returns at the falling edge after acceptance, valid still high.
   task automatic send_op(input logic [2:0] kind, input limb_type x[LIMBS],
                          input limb_type y[LIMBS], input logic sw);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_swap  <= sw;
      for (int i = 0; i < LIMBS; i++) begin
         f_drv[i] <= x[i];
         g_drv[i] <= y[i];
      end
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // sender holds off until every expected result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   stim_row_type rows[$];

   function automatic void add_row(logic [2:0] kind, limb_type fv, limb_type gv,
                                   logic sw, logic rnd, logic typed,
                                   res_type ea0, res_type ea_hi, res_type eb);
      stim_row_type r;
      r.kind = kind; r.fv = fv; r.gv = gv; r.sw = sw; r.rnd = rnd;
      r.typed = typed; r.ea0 = ea0; r.ea_hi = ea_hi; r.eb = eb;
      rows.push_back(r);
   endfunction

   initial begin
      limb_type x[LIMBS];
      limb_type y[LIMBS];
      logic [2:0] kind;
      int n_rand;

      // extremes and each special case; typed rows carry their own answer
      add_row(KIND_ADD, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(KIND_ADD, LIMB_MAX, LIMB_MAX, 0, 0, 1,
              56'hFFFFFFFFFFFFFE, 56'hFFFFFFFFFFFFFE, 0);
      add_row(KIND_ADD, LIMB_MAX, 0, 1, 0, 0, 0, 0, 0);       // swap ignored
      add_row(KIND_SUB, 0, 0, 0, 0, 1, TWO_P_LOW, TWO_P_HIGH, 0);
      add_row(KIND_SUB, LIMB_MAX, LIMB_MAX, 0, 0, 0, 0, 0, 0);
      add_row(KIND_SUB, 0, LIMB_MAX, 1, 0, 0, 0, 0, 0);       // the added 2p keeps every limb from going below zero
      add_row(KIND_SUB, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(KIND_MUL, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(KIND_MUL, LIMB_MAX, LIMB_MAX, 0, 0, 0, 0, 0, 0);
      add_row(KIND_MUL, L51_MAX, L51_MAX, 0, 0, 0, 0, 0, 0);
      add_row(KIND_MUL, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(KIND_SQUARE, LIMB_MAX, 0, 0, 0, 0, 0, 0, 0);    // g ignored
      add_row(KIND_SQUARE, 0, 0, 1, 1, 0, 0, 0, 0);
      add_row(KIND_MUL24, 1, LIMB_MAX, 0, 0, 1, 121666, 121666, 0);
      add_row(KIND_MUL24, LIMB_MAX, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_MUL24, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(KIND_CSWAP, LIMB_MAX, 0, 0, 0, 1, 56'h7FFFFFFFFFFFFF,
              56'h7FFFFFFFFFFFFF, 0);
      add_row(KIND_CSWAP, LIMB_MAX, 0, 1, 0, 1, 0, 0, 56'h7FFFFFFFFFFFFF);
      add_row(KIND_CSWAP, 0, 0, 1, 1, 0, 0, 0, 0);
      add_row(KIND_UNDEF6, LIMB_MAX, LIMB_MAX, 1, 0, 1, 0, 0, 0);
      add_row(KIND_UNDEF7, LIMB_MAX, LIMB_MAX, 0, 0, 1, 0, 0, 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, no idling
      foreach (rows[r]) begin
         for (int i = 0; i < LIMBS; i++) begin
            x[i] = rows[r].rnd ? rand_limb() : rows[r].fv;
            y[i] = rows[r].rnd ? rand_limb() : rows[r].gv;
            typed_res.a[i] = (i == 0) ? rows[r].ea0 : rows[r].ea_hi;
            typed_res.b[i] = rows[r].eb;
         end
         typed_on <= rows[r].typed;
         send_op(rows[r].kind, x, y, rows[r].sw);
      end
      typed_on <= 1'b0;
      drain();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         n_rand = N_ITEMS / 4;
         for (int n = 0; n < n_rand; n++) begin
            kind = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(5));
            for (int i = 0; i < LIMBS; i++) begin
               x[i] = rand_limb();
               y[i] = rand_limb();
            end
            send_op(kind, x, y, 1'($urandom_range(1)));
            // now and then let the pipe run dry before going on
            if (n % 100 == 50) drain();
         end
         drain();
      end

      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d results never arrived", expected_q.size());
         errors++;
      end

      $display("Ran %0d items through add/sub/mul/square/mul121666/cswap/undefined kinds",
               accepted);
      $display("%0d results checked under four idle/stall phases", checked);
      if (errors == 0) $display("PASS curve25519_field_alu_unit");
      else $display("FAIL curve25519_field_alu_unit");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAIL curve25519_field_alu_unit");
      $finish;
   end

endmodule
